[hdl/rcnt_pkg.sv]
// Shared types and codes for the three-channel root counter timer.
// Beat payload structs, request/register codes, mode word bit positions.
// No dependencies.
package rcnt_pkg;

  localparam int DATA_W      = 16;
  localparam int PULSE_W     = 8;
  localparam int NUM_TIMERS  = 3;
  localparam int PULSE_LENGTH_DEF = 8;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // tick sources
  localparam logic [1:0] SRC_SYS   = 2'd0;
  localparam logic [1:0] SRC_DIV8  = 2'd1;
  localparam logic [1:0] SRC_DOT   = 2'd2;
  localparam logic [1:0] SRC_HBL   = 2'd3;

  // register selects
  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  // timer selects
  localparam logic [1:0] TMR_0 = 2'd0;
  localparam logic [1:0] TMR_1 = 2'd1;
  localparam logic [1:0] TMR_2 = 2'd2;

  // sync modes
  localparam logic [1:0] SYNC_PAUSE = 2'd0;
  localparam logic [1:0] SYNC_RESET = 2'd1;
  localparam logic [1:0] SYNC_GATE  = 2'd2;
  localparam logic [1:0] SYNC_FREE  = 2'd3;

  // mode word bit positions
  localparam int MODE_SYNC_EN   = 0;
  localparam int MODE_SYNC_LO   = 1;
  localparam int MODE_RESET_TGT = 3;
  localparam int MODE_IRQ_TGT   = 4;
  localparam int MODE_IRQ_WRAP  = 5;
  localparam int MODE_REPEAT    = 6;
  localparam int MODE_TOGGLE    = 7;
  localparam int MODE_CLK_LO    = 8;
  localparam int MODE_IRQ_N     = 10;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [1:0]        tick_source;
    logic              hblank_level;
    logic              vblank_level;
    logic [1:0]        timer_index;
    logic [1:0]        reg_select;
    logic [DATA_W-1:0] write_data;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0]     read_data;
    logic [NUM_TIMERS-1:0] irq_mask;
  } out_t;

  // per-timer command for one processed beat
  typedef struct packed {
    logic              tick;       // tick beat: run interrupt logic
    logic              adv;        // tick matches this timer's clock
    logic              blank;      // blank level used by sync modes
    logic              fixed_sync; // sync modes ignore blank (timer 2)
    logic              wr_count;
    logic              wr_mode;
    logic              wr_target;
    logic [DATA_W-1:0] wdata;
  } tmr_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] mode;
    logic [DATA_W-1:0] target;
  } tmr_stat_t;

endpackage

[hdl/rcnt_timer.sv]
// One 16-bit root counter: counter, mode, target, hit flags, pulse counter.
// Next state for one beat is computed in a single pass and registered.
// Depends on rcnt_pkg.
module rcnt_timer #(
  parameter int PULSE_LENGTH = rcnt_pkg::PULSE_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rcnt_pkg::tmr_cmd_t  cmd,
  output rcnt_pkg::tmr_stat_t stat,
  output logic                fire
);
  import rcnt_pkg::*;

  logic [DATA_W-1:0]  count, count_next;
  logic [DATA_W-1:0]  mode, mode_next;
  logic [DATA_W-1:0]  target, target_next;
  logic               target_hit, target_hit_next;
  logic               wrap_hit, wrap_hit_next;
  logic [PULSE_W-1:0] pulse_left, pulse_left_next;
  logic               fire_next;

  always_comb begin
    logic [DATA_W:0]    v;
    logic [DATA_W-1:0]  m;
    logic               th;
    logic               wh;
    logic [PULSE_W-1:0] pl;
    logic               ev_t;
    logic               ev_w;
    logic               f;
    logic [1:0]         sm;

    v  = {1'b0, count};
    m  = mode;
    th = target_hit;
    wh = wrap_hit;
    pl = pulse_left;
    f  = 1'b0;
    ev_t = 1'b0;
    ev_w = 1'b0;
    sm = mode[MODE_SYNC_LO +: 2];
    target_next = target;

    if (cmd.tick) begin
      if (cmd.adv) begin
        if (m[MODE_SYNC_EN]) begin
          if (cmd.fixed_sync) begin
            if (sm == SYNC_RESET || sm == SYNC_GATE) v = v + 1'b1;
          end else begin
            case (sm)
              SYNC_PAUSE: if (!cmd.blank) v = v + 1'b1;
              SYNC_RESET: v = cmd.blank ? '0 : v + 1'b1;
              SYNC_GATE:  if (cmd.blank) v = '0;
              default:    if (cmd.blank) m[MODE_SYNC_EN] = 1'b0;
            endcase
          end
          if (m[MODE_RESET_TGT]) begin
            if (v > {1'b0, target}) begin
              v  = '0;
              th = 1'b1;
            end
          end else if (v[DATA_W]) begin
            v  = '0;
            wh = 1'b1;
          end
        end else begin
          v = v + 1'b1;
          if (v[DATA_W]) begin
            v  = '0;
            wh = 1'b1;
          end
        end
      end

      ev_t = m[MODE_IRQ_TGT] & th;
      ev_w = m[MODE_IRQ_WRAP] & wh;
      if (m[MODE_TOGGLE]) begin
        if (ev_t) th = 1'b0;
        if (ev_w) wh = 1'b0;
        if (m[MODE_REPEAT]) begin
          m[MODE_IRQ_N] = m[MODE_IRQ_N] ^ ev_t ^ ev_w;
          f = (ev_t | ev_w) & ~m[MODE_IRQ_N];
        end else if (ev_t | ev_w) begin
          m[MODE_IRQ_N] = 1'b0;
          f = 1'b1;
        end
      end else if (!m[MODE_IRQ_N]) begin
        // pulse still low: count it out, no new events taken
        if (pl <= PULSE_W'(1)) begin
          pl = '0;
          m[MODE_IRQ_N] = 1'b1;
        end else begin
          pl = pl - 1'b1;
        end
        if (!m[MODE_REPEAT]) begin
          m[MODE_IRQ_TGT]  = 1'b0;
          m[MODE_IRQ_WRAP] = 1'b0;
        end
      end else if (ev_t | ev_w) begin
        if (ev_t) th = 1'b0;
        if (ev_w) wh = 1'b0;
        m[MODE_IRQ_N] = 1'b0;
        pl = PULSE_W'(PULSE_LENGTH);
        f  = 1'b1;
      end
    end else begin
      if (cmd.wr_count) v = {1'b0, cmd.wdata};
      if (cmd.wr_mode) begin
        m  = cmd.wdata;
        m[MODE_IRQ_N] = 1'b1;
        v  = '0;
        th = 1'b0;
        wh = 1'b0;
      end
      if (cmd.wr_target) target_next = cmd.wdata;
    end

    count_next      = v[DATA_W-1:0];
    mode_next       = m;
    target_hit_next = th;
    wrap_hit_next   = wh;
    pulse_left_next = pl;
    fire_next       = f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      mode       <= '0;
      target     <= '0;
      target_hit <= 1'b0;
      wrap_hit   <= 1'b0;
      pulse_left <= PULSE_W'(PULSE_LENGTH);
    end else begin
      count      <= count_next;
      mode       <= mode_next;
      target     <= target_next;
      target_hit <= target_hit_next;
      wrap_hit   <= wrap_hit_next;
      pulse_left <= pulse_left_next;
    end
  end

  assign stat.count  = count;
  assign stat.mode   = mode;
  assign stat.target = target;
  assign fire        = fire_next;

  // a mode write restarts the counter, sets the request bit high and clears both hit flags
  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_mode && !cmd.tick |=> count == '0 && mode[MODE_IRQ_N] && !target_hit && !wrap_hit)
    else $error("mode write did not restart timer");

  // an interrupt is only raised while the request bit goes low
  a_fire_low: assert property (@(posedge clk) disable iff (rst)
    fire |=> !mode[MODE_IRQ_N])
    else $error("interrupt raised with request bit high");

  a_fire_on_tick: assert property (@(posedge clk) disable iff (rst)
    fire |-> cmd.tick)
    else $error("interrupt raised outside a tick beat");

endmodule

[hdl/three_channel_root_counter_timer_unit.sv]
// Three-channel root counter timer: top level with input and result registers.
// Path: input register, then result register; the result register is loaded while a new
// beat enters. Throughput: one beat per cycle while out_ready does not stall the output.
// Reset (rst, synchronous): counters, modes, targets and hit flags cleared,
// pulse counters loaded with PULSE_LENGTH, both registers empty.
// Depends on rcnt_pkg and rcnt_timer.
module three_channel_root_counter_timer_unit #(
  parameter int PULSE_LENGTH = rcnt_pkg::PULSE_LENGTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rcnt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rcnt_pkg::out_t out_data
);
  import rcnt_pkg::*;

  in_t                   in_q;
  logic                  in_q_valid;
  logic                  step;
  tmr_cmd_t              cmd [NUM_TIMERS];
  tmr_stat_t             stat [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] fire;
  logic [DATA_W-1:0]     rd;
  logic                  is_tick, is_read, is_write;
  logic                  dot0, hsrc1, div2;
  logic                  adv [NUM_TIMERS];
  tmr_stat_t             sel;
  logic                  sel_ok;

  assign step     = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_ready && in_valid) in_q <= in_data;
  end

  assign is_tick  = step && in_q.req_type == REQ_TICK;
  assign is_read  = in_q.req_type == REQ_READ;
  assign is_write = step && in_q.req_type == REQ_WRITE;

  // clock select per timer
  assign dot0  = stat[0].mode[MODE_CLK_LO];
  assign hsrc1 = stat[1].mode[MODE_CLK_LO];
  assign div2  = stat[2].mode[MODE_CLK_LO + 1];

  assign adv[0] = (in_q.tick_source == SRC_SYS && !dot0) ||
                  (in_q.tick_source == SRC_DOT && dot0);
  assign adv[1] = (in_q.tick_source == SRC_SYS && !hsrc1) ||
                  (in_q.tick_source == SRC_HBL && hsrc1);
  assign adv[2] = (in_q.tick_source == SRC_SYS && !div2) ||
                  (in_q.tick_source == SRC_DIV8 && div2);

  always_comb begin
    sel_ok = 1'b1;
    case (in_q.timer_index)
      TMR_0:   sel = stat[0];
      TMR_1:   sel = stat[1];
      TMR_2:   sel = stat[2];
      default: begin
        sel    = '0;
        sel_ok = 1'b0;
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < NUM_TIMERS; g++) begin : g_tmr
      logic hit;
      assign hit = is_write && in_q.timer_index == 2'(g);
      always_comb begin
        cmd[g].tick       = is_tick;
        cmd[g].adv        = adv[g];
        cmd[g].blank      = (g == 0) ? in_q.hblank_level :
                            (g == 1) ? in_q.vblank_level : 1'b0;
        cmd[g].fixed_sync = (g == NUM_TIMERS - 1);
        cmd[g].wr_count   = hit && in_q.reg_select == REG_COUNT;
        cmd[g].wr_mode    = hit && in_q.reg_select == REG_MODE;
        cmd[g].wr_target  = hit && in_q.reg_select == REG_TARGET;
        cmd[g].wdata      = in_q.write_data;
      end
      rcnt_timer #(
        .PULSE_LENGTH(PULSE_LENGTH)
      ) u_timer (
        .clk  (clk),
        .rst  (rst),
        .cmd  (cmd[g]),
        .stat (stat[g]),
        .fire (fire[g])
      );
    end
  endgenerate

  always_comb begin
    rd = '0;
    if (is_read && sel_ok) begin
      case (in_q.reg_select)
        REG_COUNT:  rd = sel.count;
        REG_MODE:   rd = sel.mode;
        REG_TARGET: rd = sel.target;
        default:    rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (step) begin
      out_data.read_data <= rd;
      out_data.irq_mask  <= fire;
    end
  end

  a_no_irq_off_tick: assert property (@(posedge clk) disable iff (rst)
    step && in_q.req_type != REQ_TICK |=> out_data.irq_mask == '0)
    else $error("interrupt mask on a non-tick beat");

  a_no_data_off_read: assert property (@(posedge clk) disable iff (rst)
    step && in_q.req_type != REQ_READ |=> out_data.read_data == '0)
    else $error("read data on a non-read beat");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

[tb/three_channel_root_counter_timer_unit_tb.sv]
// Self-checking bench for three_channel_root_counter_timer_unit: timer predictor, directed and
// random beats, random stalls on both channels, two long output hold-offs.
// Depends on rcnt_pkg and the unit's RTL.
module three_channel_root_counter_timer_unit_tb;
  import rcnt_pkg::*;

  localparam int PULSE_LEN = PULSE_LENGTH_DEF;
  localparam int RANDOM_GOAL = 1350;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 4;
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_MAX = 10;

  // codes the package leaves out: unused request and unmapped addresses
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [1:0] TMR_NONE = 2'd3;
  localparam logic [1:0] REG_NONE = 2'd3;
  // clock select values
  localparam logic [1:0] CLK_ALT  = 2'b01;  // dot (t0) / hblank (t1)
  localparam logic [1:0] CLK_DIV8 = 2'b10;  // system/8 (t2)

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // predicted timer state
  logic [DATA_W-1:0]  tmr_count  [NUM_TIMERS];
  logic [DATA_W-1:0]  tmr_mode   [NUM_TIMERS];
  logic [DATA_W-1:0]  tmr_target [NUM_TIMERS];
  logic               tgt_flag   [NUM_TIMERS];
  logic               wrap_flag  [NUM_TIMERS];
  logic [PULSE_W-1:0] pulse_cnt  [NUM_TIMERS];

  out_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned irq_results = 0;
  int unsigned live_beats = 0;
  int unsigned cycle_count = 0;

  bit quiet = 1'b0;
  int unsigned hold_token = 0;
  int unsigned hold_ack = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_gap = 0;

  three_channel_root_counter_timer_unit #(.PULSE_LENGTH(PULSE_LEN)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic void advance_timer(int t, logic blank);
    logic [DATA_W:0]   v;
    logic [DATA_W-1:0] m;
    v = {1'b0, tmr_count[t]};
    m = tmr_mode[t];
    if (m[MODE_SYNC_EN]) begin
      if (t == TMR_2) begin
        if (m[MODE_SYNC_LO +: 2] == SYNC_RESET || m[MODE_SYNC_LO +: 2] == SYNC_GATE) v++;
      end else begin
        case (m[MODE_SYNC_LO +: 2])
          SYNC_PAUSE: if (!blank) v++;
          SYNC_RESET: begin
            v++;
            if (blank) v = '0;
          end
          SYNC_GATE: if (blank) v = '0;
          default: if (blank) tmr_mode[t][MODE_SYNC_EN] = 1'b0;
        endcase
      end
      if (m[MODE_RESET_TGT]) begin
        if (v > {1'b0, tmr_target[t]}) begin
          v = '0;
          tgt_flag[t] = 1'b1;
        end
      end else if (v[DATA_W]) begin
        v = '0;
        wrap_flag[t] = 1'b1;
      end
    end else begin
      v++;
      if (v[DATA_W]) begin
        v = '0;
        wrap_flag[t] = 1'b1;
      end
    end
    tmr_count[t] = v[DATA_W-1:0];
  endfunction

  function automatic logic timer_irq(int t);
    logic [DATA_W-1:0] m;
    logic ev_t, ev_w, fire;
    int   n_ev;
    m = tmr_mode[t];
    ev_t = m[MODE_IRQ_TGT] && tgt_flag[t];
    ev_w = m[MODE_IRQ_WRAP] && wrap_flag[t];
    n_ev = int'(ev_t) + int'(ev_w);
    fire = 1'b0;
    // events are consumed unless a pulse is still running
    if (m[MODE_TOGGLE] || m[MODE_IRQ_N]) begin
      if (ev_t) tgt_flag[t] = 1'b0;
      if (ev_w) wrap_flag[t] = 1'b0;
    end
    if (m[MODE_TOGGLE]) begin
      repeat (n_ev) begin
        if (m[MODE_REPEAT]) begin
          m[MODE_IRQ_N] = ~m[MODE_IRQ_N];
          fire = !m[MODE_IRQ_N];
        end else begin
          m[MODE_IRQ_N] = 1'b0;
          fire = 1'b1;
        end
      end
    end else if (!m[MODE_IRQ_N]) begin
      if (pulse_cnt[t] <= 1) begin
        pulse_cnt[t] = '0;
        m[MODE_IRQ_N] = 1'b1;
      end else begin
        pulse_cnt[t] = pulse_cnt[t] - 1'b1;
      end
      if (!m[MODE_REPEAT]) begin
        m[MODE_IRQ_TGT]  = 1'b0;
        m[MODE_IRQ_WRAP] = 1'b0;
      end
    end else if (n_ev != 0) begin
      m[MODE_IRQ_N] = 1'b0;
      pulse_cnt[t] = PULSE_W'(PULSE_LEN);
      fire = 1'b1;
    end
    tmr_mode[t] = m;
    return fire;
  endfunction

  function automatic out_t predict_beat(in_t b);
    out_t r;
    logic dot0, hsrc1, div2;
    logic [DATA_W-1:0] wd;
    r = '0;
    case (b.req_type)
      REQ_TICK: begin
        dot0  = tmr_mode[0][MODE_CLK_LO];
        hsrc1 = tmr_mode[1][MODE_CLK_LO];
        div2  = tmr_mode[2][MODE_CLK_LO + 1];
        case (b.tick_source)
          SRC_SYS: begin
            if (!dot0) advance_timer(0, b.hblank_level);
            if (!hsrc1) advance_timer(1, b.vblank_level);
            if (!div2) advance_timer(2, 1'b0);
          end
          SRC_DIV8: if (div2) advance_timer(2, 1'b0);
          SRC_DOT:  if (dot0) advance_timer(0, b.hblank_level);
          default:  if (hsrc1) advance_timer(1, b.vblank_level);
        endcase
        for (int t = 0; t < NUM_TIMERS; t++)
          if (timer_irq(t)) r.irq_mask[t] = 1'b1;
      end
      REQ_READ: if (b.timer_index <= TMR_2) begin
        case (b.reg_select)
          REG_COUNT:  r.read_data = tmr_count[b.timer_index];
          REG_MODE:   r.read_data = tmr_mode[b.timer_index];
          REG_TARGET: r.read_data = tmr_target[b.timer_index];
          default: ;
        endcase
      end
      REQ_WRITE: if (b.timer_index <= TMR_2) begin
        case (b.reg_select)
          REG_COUNT: tmr_count[b.timer_index] = b.write_data;
          REG_MODE: begin
            wd = b.write_data;
            wd[MODE_IRQ_N] = 1'b1;
            tmr_mode[b.timer_index]  = wd;
            tmr_count[b.timer_index] = '0;
            tgt_flag[b.timer_index]  = 1'b0;
            wrap_flag[b.timer_index] = 1'b0;
          end
          REG_TARGET: tmr_target[b.timer_index] = b.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_t make_beat(input logic [1:0] req, src, input logic hb, vb,
                                    input logic [1:0] ti, rs, input logic [DATA_W-1:0] wd);
    in_t b;
    b.req_type     = req;
    b.tick_source  = src;
    b.hblank_level = hb;
    b.vblank_level = vb;
    b.timer_index  = ti;
    b.reg_select   = rs;
    b.write_data   = wd;
    return b;
  endfunction

  function automatic in_t random_beat();
    return make_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     DATA_W'($urandom));
  endfunction

  // one beat: optional idle gap, then hold valid until accepted
  task automatic send_beat(input in_t beat);
    int unsigned gap;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_beat(beat));
    if (beat.req_type == REQ_TICK ||
        ((beat.req_type == REQ_READ || beat.req_type == REQ_WRITE) &&
         beat.timer_index <= TMR_2 && beat.reg_select <= REG_TARGET))
      live_beats++;
  endtask

  task automatic tick(input logic [1:0] src, input logic hb, vb);
    send_beat(make_beat(REQ_TICK, src, hb, vb, TMR_0, REG_COUNT, '0));
  endtask

  task automatic reg_read(input logic [1:0] ti, rs);
    send_beat(make_beat(REQ_READ, SRC_SYS, 1'b0, 1'b0, ti, rs, '0));
  endtask

  task automatic reg_write(input logic [1:0] ti, rs, input logic [DATA_W-1:0] wd);
    send_beat(make_beat(REQ_WRITE, SRC_SYS, 1'b0, 1'b0, ti, rs, wd));
  endtask

  // must follow the last send directly so valid drops in the same step
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------- tests ----------------
  task automatic test_reset_state();
    reg_read(TMR_0, REG_COUNT);
    reg_read(TMR_1, REG_MODE);
    reg_read(TMR_2, REG_TARGET);
    drain();
  endtask

  task automatic test_bad_access();
    reg_write(TMR_NONE, REG_COUNT, 16'hFFFF);
    reg_write(TMR_0, REG_NONE, 16'hFFFF);
    reg_read(TMR_NONE, REG_MODE);
    reg_read(TMR_1, REG_NONE);
    send_beat(make_beat(REQ_NONE, SRC_HBL, 1'b1, 1'b1, TMR_NONE, REG_NONE, 16'hFFFF));
    reg_read(TMR_0, REG_COUNT);
    drain();
  endtask

  // free-running timer 0 wraps past 0xFFFF, toggle-once interrupt
  task automatic test_wrap_toggle();
    logic [DATA_W-1:0] m;
    m = '0;
    m[MODE_IRQ_WRAP] = 1'b1;
    m[MODE_TOGGLE]   = 1'b1;
    reg_write(TMR_0, REG_MODE, m);
    reg_write(TMR_0, REG_COUNT, 16'hFFFF);
    tick(SRC_SYS, 1'b0, 1'b0);
    reg_read(TMR_0, REG_MODE);
    drain();
  endtask

  // timer 2 on system/8, target 0, repeat pulse: fires then counts the pulse down
  task automatic test_target_pulse();
    logic [DATA_W-1:0] m;
    m = '0;
    m[MODE_SYNC_EN]          = 1'b1;
    m[MODE_SYNC_LO +: 2]     = SYNC_RESET;
    m[MODE_RESET_TGT]        = 1'b1;
    m[MODE_IRQ_TGT]          = 1'b1;
    m[MODE_REPEAT]           = 1'b1;
    m[MODE_CLK_LO +: 2]      = CLK_DIV8;
    reg_write(TMR_2, REG_MODE, m);
    reg_write(TMR_2, REG_TARGET, 16'h0000);
    repeat (4) tick(SRC_DIV8, 1'b0, 1'b0);
    tick(SRC_SYS, 1'b1, 1'b1);
    drain();
  endtask

  // timer 1 on hblank source, free-run after blank clears sync enable
  task automatic test_sync_blank();
    logic [DATA_W-1:0] m;
    m = '0;
    m[MODE_SYNC_EN]      = 1'b1;
    m[MODE_SYNC_LO +: 2] = SYNC_FREE;
    m[MODE_CLK_LO +: 2]  = CLK_ALT;
    reg_write(TMR_1, REG_MODE, m);
    tick(SRC_HBL, 1'b0, 1'b1);
    reg_read(TMR_1, REG_MODE);
    drain();
  endtask

  // program one timer, then a burst of ticks mostly on its own clock
  task automatic test_random_mix();
    int unsigned tmr;
    logic [DATA_W-1:0] m;
    logic [1:0] own_src;
    logic hb, vb;
    hb = 1'b0;
    vb = 1'b0;
    while (live_beats < RANDOM_GOAL) begin
      quiet <= ($urandom_range(0, 4) == 0);
      tmr = $urandom_range(0, 2);
      m = DATA_W'($urandom);
      if ($urandom_range(0, 2) != 0) m[MODE_IRQ_TGT + $urandom_range(0, 1)] = 1'b1;
      reg_write(2'(tmr), REG_MODE, m);
      if ($urandom_range(0, 1))
        reg_write(2'(tmr), REG_TARGET,
                  DATA_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 24) : $urandom));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 2))
          0: reg_write(2'(tmr), REG_COUNT, DATA_W'(32'hFFFF - $urandom_range(0, 12)));
          1: reg_write(2'(tmr), REG_COUNT, DATA_W'($urandom_range(0, 24)));
          default: reg_write(2'(tmr), REG_COUNT, DATA_W'($urandom));
        endcase
      end
      case (tmr)
        0: own_src = m[MODE_CLK_LO] ? SRC_DOT : SRC_SYS;
        1: own_src = m[MODE_CLK_LO] ? SRC_HBL : SRC_SYS;
        default: own_src = m[MODE_CLK_LO + 1] ? SRC_DIV8 : SRC_SYS;
      endcase
      repeat ($urandom_range(8, 40)) begin
        // blank levels move in runs
        if ($urandom_range(0, 5) == 0) hb = ~hb;
        if ($urandom_range(0, 5) == 0) vb = ~vb;
        case ($urandom_range(0, 19))
          0, 1: reg_read(2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)));
          2: send_beat(random_beat());
          3, 4, 5, 6: tick(2'($urandom_range(0, 3)), hb, vb);
          default: tick(own_src, hb, vb);
        endcase
      end
    end
    drain();
    quiet <= 1'b0;
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_output_hold();
    hold_token <= hold_token + 1;
    repeat (48) begin
      if ($urandom_range(0, 3) == 0) send_beat(random_beat());
      else tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
      rx_hold   <= 0;
    end else if (hold_ack != hold_token) begin
      hold_ack  <= hold_token;
      rx_hold   <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap    <= rx_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_gap    <= quiet ? 0 : idle_len();
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_data.irq_mask != '0) irq_results++;
      if (expected_results.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("result beat %0d with nothing expected: read_data %h irq_mask %b",
                   results_seen, out_data.read_data, out_data.irq_mask);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_data !== want.read_data || out_data.irq_mask !== want.irq_mask) begin
          if (mismatch_count < REPORT_MAX)
            $display("result beat %0d: read_data exp %h got %h, irq_mask exp %b got %b",
                     results_seen, want.read_data, out_data.read_data,
                     want.irq_mask, out_data.irq_mask);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    for (int t = 0; t < NUM_TIMERS; t++) begin
      tmr_count[t]  = '0;
      tmr_mode[t]   = '0;
      tmr_target[t] = '0;
      tgt_flag[t]   = 1'b0;
      wrap_flag[t]  = 1'b0;
      pulse_cnt[t]  = PULSE_W'(PULSE_LEN);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_bad_access();
    test_wrap_toggle();
    test_target_pulse();
    test_sync_blank();
    test_output_hold();
    test_random_mix();
    test_output_hold();
    $display("covered %0d live beats over ticks, reads and writes in %0d cycles",
             live_beats, cycle_count);
    $display("%0d result beats checked, %0d carried interrupts, %0d mismatches",
             results_seen, irq_results, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
